### design/bbta_pkg.sv
// Shared types and constants of the buddy bit-tree allocator.
// Holds the item structs, cell state, operation and status codes and the arena reset value.
// No dependencies.
package bbta_pkg;

   typedef logic [1:0] cell_type;

   localparam cell_type CELL_FREE  = 2'b00;
   localparam cell_type CELL_SPLIT = 2'b10;
   localparam cell_type CELL_FULL  = 2'b11;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_ZERO_SIZE  = 2'd1;
   localparam logic [1:0] STATUS_NO_FIT     = 2'd2;
   localparam logic [1:0] STATUS_BAD_OFFSET = 2'd3;

   localparam logic [31:0] ARENA_RESET = 32'd4096;

   typedef struct packed {
      logic        operation;
      logic [31:0] request_size;
      logic [31:0] free_offset;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] block_offset;
      logic [31:0] bytes_in_use;
      logic [31:0] bytes_free;
   } rsp_type;

endpackage

### design/bbta_cell_mem.sv
// Cell state memory of the buddy bit-tree allocator: one write port and one
// read port with registered read data.
// Depends on bbta_pkg for the cell state type.
module bbta_cell_mem #(
   parameter int IDX_W = 4
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [IDX_W-1:0]     wr_addr,
   input  bbta_pkg::cell_type   wr_data,
   input  logic [IDX_W-1:0]     rd_addr,
   output bbta_pkg::cell_type   rd_data
);

   localparam int CELL_DEPTH = 1 << IDX_W;

   bbta_pkg::cell_type cells_ff [CELL_DEPTH];
   bbta_pkg::cell_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cells_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= cells_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/buddy_bit_tree_allocator_top.sv
// Top level of the buddy bit-tree allocator: sequencer, shared shift and add unit,
// totals and the result register.
// Depends on bbta_pkg and bbta_cell_mem.
//
// Usage. Items arrive on the req_ channel (valid/ready) and each one gives
// exactly one result item on the rsp_ channel (valid/ready). An item either
// allocates a block of request_size bytes or frees the block that starts at
// free_offset. The arena size register is written through csr_write_en and
// csr_write_data, and should only be written while the block is idle.
// Work on an item is sequenced over one shared shifter (arena >> depth) and
// one 33-bit adder/subtractor, with the cell states held in a small memory
// that has one read and one write port and a registered read.
// Steps: an allocate runs a check, a level selection down to the deepest level
// whose block still fits, a depth-first search that reads and then weighs each
// tree cell visited, with a further step for each move to a sibling or step back
// up, a marking pass from the chosen cell up to the root, the total and the
// hand-over of the result. A free runs a check, a walk down to the held block,
// the release, a merge pass that looks at each buddy on the way up, and the
// hand-over. A zero size, an oversized request or an offset past the arena goes
// from its check straight to the hand-over.
// The block takes one item at a time; req_ready is high only when it is idle.
// After reset a clearing pass writes every cell to free, during which no item
// is taken (the arena register may still be written).
// A finished result sits in an output register, so a stalled receiver does not
// stop the next item being taken; the block waits only if a second result is
// ready before the first has been taken.
module buddy_bit_tree_allocator_top #(
   parameter int TREE_LEVELS = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bbta_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bbta_pkg::rsp_type rsp_data,
   input  logic              csr_write_en,
   input  logic [31:0]       csr_write_data
);

   localparam int IDX_W   = TREE_LEVELS;
   localparam int DEPTH_W = $clog2(TREE_LEVELS + 1);
   localparam logic [DEPTH_W-1:0] LAST_DEPTH = DEPTH_W'(TREE_LEVELS - 1);
   localparam logic [IDX_W-1:0]   ROOT_CELL  = IDX_W'(1);

   // Sequencer state codes.
   localparam logic [3:0] S_CLEAR     = 4'd0;
   localparam logic [3:0] S_IDLE      = 4'd1;
   localparam logic [3:0] S_ALLOC_CHK = 4'd2;
   localparam logic [3:0] S_LEVEL     = 4'd3;
   localparam logic [3:0] S_VISIT_RD  = 4'd4;
   localparam logic [3:0] S_VISIT_EV  = 4'd5;
   localparam logic [3:0] S_NEXT      = 4'd6;
   localparam logic [3:0] S_MARK      = 4'd7;
   localparam logic [3:0] S_ADD       = 4'd8;
   localparam logic [3:0] S_FREE_CHK  = 4'd9;
   localparam logic [3:0] S_WALK_RD   = 4'd10;
   localparam logic [3:0] S_WALK_EV   = 4'd11;
   localparam logic [3:0] S_RELEASE   = 4'd12;
   localparam logic [3:0] S_MERGE_RD  = 4'd13;
   localparam logic [3:0] S_MERGE_EV  = 4'd14;
   localparam logic [3:0] S_DONE      = 4'd15;

   logic [3:0]         state_ff, state_in;
   logic               op_ff, op_in;
   logic [31:0]        size_ff, size_in;
   logic [31:0]        off_ff, off_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [DEPTH_W-1:0] cd_ff, cd_in;
   logic [IDX_W-1:0]   cell_ff, cell_in;
   logic [31:0]        offset_ff, offset_in;
   logic [31:0]        total_ff, total_in;
   logic [31:0]        arena_ff, arena_in;
   logic [1:0]         status_ff, status_in;
   logic [IDX_W-1:0]   clr_ff, clr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   bbta_pkg::rsp_type  rsp_ff, rsp_in;

   // Shared arithmetic: one variable right shift of the arena size and one adder.
   logic [DEPTH_W-1:0] shamt;
   logic [31:0]        shifted;
   logic [31:0]        au_a, au_b;
   logic               au_sub;
   logic [32:0]        au_res;

   logic                mem_wr_en;
   logic [IDX_W-1:0]    mem_wr_addr;
   bbta_pkg::cell_type  mem_wr_data;
   logic [IDX_W-1:0]    mem_rd_addr;
   bbta_pkg::cell_type  mem_rd_data;

   logic req_fire;

   bbta_cell_mem #(
      .IDX_W (IDX_W)
   ) u_cells (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Operand selection for the shared unit, by sequencer state.
   always_comb begin
      shamt  = depth_ff;
      au_a   = total_ff;
      au_b   = shifted;
      au_sub = 1'b0;
      case (state_ff)
         S_ALLOC_CHK: begin
            au_a   = arena_ff;
            au_b   = size_ff;
            au_sub = 1'b1;
         end
         S_LEVEL: begin
            shamt  = depth_ff + DEPTH_W'(1);
            au_a   = shifted;
            au_b   = size_ff;
            au_sub = 1'b1;
         end
         S_MARK: begin
            shamt = cd_ff;
            au_a  = offset_ff;
         end
         S_ADD: begin
            shamt = depth_ff;
         end
         S_FREE_CHK: begin
            au_a   = off_ff;
            au_b   = arena_ff;
            au_sub = 1'b1;
         end
         S_WALK_EV: begin
            shamt  = cd_ff + DEPTH_W'(1);
            au_a   = off_ff;
            au_sub = 1'b1;
         end
         S_RELEASE: begin
            shamt  = cd_ff;
            au_sub = 1'b1;
         end
         S_DONE: begin
            au_a   = arena_ff;
            au_b   = total_ff;
            au_sub = 1'b1;
         end
         default: begin
            shamt = depth_ff;
         end
      endcase
   end

   assign shifted = arena_ff >> shamt;
   assign au_res  = au_sub ? ({1'b0, au_a} - {1'b0, au_b})
                           : ({1'b0, au_a} + {1'b0, au_b});

   // Sequencer. A set top bit of au_res after a subtraction is a borrow.
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      size_in      = size_ff;
      off_in       = off_ff;
      depth_in     = depth_ff;
      cd_in        = cd_ff;
      cell_in      = cell_ff;
      offset_in    = offset_ff;
      total_in     = total_ff;
      arena_in     = csr_write_en ? csr_write_data : arena_ff;
      status_in    = status_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = cell_ff;
      mem_wr_data  = bbta_pkg::CELL_FREE;
      mem_rd_addr  = cell_ff;

      case (state_ff)
         S_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            clr_in      = clr_ff + IDX_W'(1);
            if (clr_ff == {IDX_W{1'b1}}) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               op_in     = req_data.operation;
               size_in   = req_data.request_size;
               off_in    = req_data.free_offset;
               offset_in = '0;
               status_in = bbta_pkg::STATUS_OK;
               state_in  = (req_data.operation == bbta_pkg::OP_FREE) ? S_FREE_CHK
                                                                    : S_ALLOC_CHK;
            end
         end
         S_ALLOC_CHK: begin
            depth_in = '0;
            if (size_ff == 32'd0) begin
               status_in = bbta_pkg::STATUS_ZERO_SIZE;
               state_in  = S_DONE;
            end else if (au_res[32]) begin
               status_in = bbta_pkg::STATUS_NO_FIT;
               state_in  = S_DONE;
            end else begin
               state_in = S_LEVEL;
            end
         end
         S_LEVEL: begin
            if (depth_ff != LAST_DEPTH && !au_res[32]) begin
               depth_in = depth_ff + DEPTH_W'(1);
            end else begin
               cell_in  = ROOT_CELL;
               cd_in    = '0;
               state_in = S_VISIT_RD;
            end
         end
         S_VISIT_RD: begin
            state_in = S_VISIT_EV;
         end
         S_VISIT_EV: begin
            if (cd_ff == depth_ff) begin
               state_in = (mem_rd_data == bbta_pkg::CELL_FREE) ? S_MARK : S_NEXT;
            end else if (mem_rd_data == bbta_pkg::CELL_FULL) begin
               state_in = S_NEXT;
            end else begin
               cell_in  = cell_ff << 1;
               cd_in    = cd_ff + DEPTH_W'(1);
               state_in = S_VISIT_RD;
            end
         end
         S_NEXT: begin
            if (cell_ff == ROOT_CELL) begin
               status_in = bbta_pkg::STATUS_NO_FIT;
               state_in  = S_DONE;
            end else if (cell_ff[0]) begin
               cell_in = cell_ff >> 1;
               cd_in   = cd_ff - DEPTH_W'(1);
            end else begin
               cell_in  = cell_ff | IDX_W'(1);
               state_in = S_VISIT_RD;
            end
         end
         S_MARK: begin
            // The chosen cell becomes full, every ancestor split; right turns
            // on the way up add their half size to the offset.
            mem_wr_en   = 1'b1;
            mem_wr_data = (cd_ff == depth_ff) ? bbta_pkg::CELL_FULL : bbta_pkg::CELL_SPLIT;
            if (cell_ff[0] && cd_ff != '0) begin
               offset_in = au_res[31:0];
            end
            if (cell_ff == ROOT_CELL) begin
               state_in = S_ADD;
            end else begin
               cell_in = cell_ff >> 1;
               cd_in   = cd_ff - DEPTH_W'(1);
            end
         end
         S_ADD: begin
            total_in = au_res[32] ? 32'hFFFF_FFFF : au_res[31:0];
            state_in = S_DONE;
         end
         S_FREE_CHK: begin
            if (!au_res[32]) begin
               status_in = bbta_pkg::STATUS_BAD_OFFSET;
               state_in  = S_DONE;
            end else begin
               cell_in  = ROOT_CELL;
               cd_in    = '0;
               state_in = S_WALK_RD;
            end
         end
         S_WALK_RD: begin
            state_in = S_WALK_EV;
         end
         S_WALK_EV: begin
            if (mem_rd_data == bbta_pkg::CELL_FULL) begin
               if (off_ff != 32'd0) begin
                  status_in = bbta_pkg::STATUS_BAD_OFFSET;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_RELEASE;
               end
            end else if (mem_rd_data != bbta_pkg::CELL_SPLIT || cd_ff == LAST_DEPTH) begin
               status_in = bbta_pkg::STATUS_BAD_OFFSET;
               state_in  = S_DONE;
            end else begin
               cd_in    = cd_ff + DEPTH_W'(1);
               state_in = S_WALK_RD;
               if (au_res[32]) begin
                  cell_in = cell_ff << 1;
               end else begin
                  off_in  = au_res[31:0];
                  cell_in = (cell_ff << 1) | IDX_W'(1);
               end
            end
         end
         S_RELEASE: begin
            mem_wr_en = 1'b1;
            total_in  = au_res[32] ? 32'd0 : au_res[31:0];
            state_in  = S_MERGE_RD;
         end
         S_MERGE_RD: begin
            // The current cell is known free; only its buddy needs a look.
            mem_rd_addr = cell_ff ^ IDX_W'(1);
            state_in    = (cell_ff == ROOT_CELL) ? S_DONE : S_MERGE_EV;
         end
         S_MERGE_EV: begin
            if (mem_rd_data == bbta_pkg::CELL_FREE) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = cell_ff >> 1;
               cell_in     = cell_ff >> 1;
               state_in    = S_MERGE_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in        = 1'b1;
               rsp_in.status       = status_ff;
               rsp_in.block_offset = offset_ff;
               rsp_in.bytes_in_use = total_ff;
               rsp_in.bytes_free   = au_res[32] ? 32'd0 : au_res[31:0];
               state_in            = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         total_ff     <= '0;
         arena_ff     <= bbta_pkg::ARENA_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         total_ff     <= total_in;
         arena_ff     <= arena_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      size_ff   <= size_in;
      off_ff    <= off_in;
      depth_ff  <= depth_in;
      cd_ff     <= cd_in;
      cell_ff   <= cell_in;
      offset_ff <= offset_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   // The search never goes deeper than the level chosen for the request.
   a_search_depth: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_VISIT_EV) |-> (cd_ff <= depth_ff))
      else $error("search went below the target level");

   // Cell zero is unused outside the clearing pass.
   a_no_cell_zero: assert property (@(posedge clock) disable iff (reset)
      (mem_wr_en && state_ff != S_CLEAR) |-> (mem_wr_addr != '0))
      else $error("write to unused cell zero");

   // Adding a block never lowers the bytes in use.
   a_total_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ADD) |=> (total_ff >= $past(total_ff)))
      else $error("bytes in use fell on an allocate");

   // Buddy merging only happens while an item frees a block.
   a_merge_on_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MERGE_RD || state_ff == S_MERGE_EV) |-> (op_ff == bbta_pkg::OP_FREE))
      else $error("merge pass during an allocate");

endmodule

### bench/testbench.sv
// Self-checking bench for the buddy bit-tree allocator top level.
// Depends on bbta_pkg (item types, status and cell codes) and the design itself.
// A scoreboard class predicts every result from its own copy of the cell tree.
module testbench;

   // The bench assumes the default tree depth of the design.
   localparam int LEVELS        = 4;
   localparam int CELL_SLOTS    = 1 << LEVELS;
   localparam int RANDOM_ITEMS  = 750;
   localparam int RANDOM_PHASES = 8;
   // The limit lies above the slowest correct run: roughly 800 items, each with
   // its search, sender gap and receiver stall, plus the clearing pass after reset.
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 80;

   // Scoreboard: keeps its own cell tree, arena size and byte total, predicts the
   // result of every accepted item and compares the results in order.
   class alloc_result_board;
      bbta_pkg::cell_type cells [CELL_SLOTS];
      logic [31:0]        arena;
      logic [31:0]        in_use;
      bbta_pkg::rsp_type  expected_results [$];
      int                 error_count;

      function new();
         foreach (cells[i]) cells[i] = bbta_pkg::CELL_FREE;
         arena       = bbta_pkg::ARENA_RESET;
         in_use      = '0;
         error_count = 0;
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         $display("%0t: %s: got %h, expected %h", $time, what, got, want);
         error_count++;
      endtask

      function void set_arena(logic [31:0] value);
         arena = value;
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      // Start offset of the cell at index c, depth d: each right turn on the
      // way down adds the rounded-down half size of that level.
      function logic [31:0] path_offset(int c, int d);
         logic [31:0] offset;
         offset = '0;
         for (int k = 0; k < d; k++) begin
            if (((c >> (d - 1 - k)) & 1) != 0) offset += arena >> (k + 1);
         end
         return offset;
      endfunction

      function logic [1:0] allocate(logic [31:0] size, output logic [31:0] offset);
         int          depth;
         int          chosen;
         int          a;
         bit          ok;
         logic [32:0] sum;
         offset = '0;
         chosen = 0;
         if (size == 0) return bbta_pkg::STATUS_ZERO_SIZE;
         if (size > arena) return bbta_pkg::STATUS_NO_FIT;
         depth = 0;
         while (depth + 1 < LEVELS && size <= (arena >> (depth + 1))) depth++;
         // Leftmost free cell at that depth that has no full cell above it.
         for (int c = 1 << depth; c < (2 << depth) && chosen == 0; c++) begin
            ok = (cells[c] == bbta_pkg::CELL_FREE);
            a  = c >> 1;
            while (ok && a != 0) begin
               if (cells[a] == bbta_pkg::CELL_FULL) ok = 0;
               a = a >> 1;
            end
            if (ok) chosen = c;
         end
         if (chosen == 0) return bbta_pkg::STATUS_NO_FIT;
         cells[chosen] = bbta_pkg::CELL_FULL;
         for (a = chosen >> 1; a != 0; a = a >> 1) cells[a] = bbta_pkg::CELL_SPLIT;
         offset = path_offset(chosen, depth);
         sum    = {1'b0, in_use} + {1'b0, arena >> depth};
         in_use = sum[32] ? '1 : sum[31:0];
         return bbta_pkg::STATUS_OK;
      endfunction

      function logic [1:0] free_block(logic [31:0] offset);
         int          c;
         int          depth;
         bit          done;
         bit          bad;
         logic [31:0] half;
         logic [31:0] size;
         if (offset >= arena) return bbta_pkg::STATUS_BAD_OFFSET;
         c     = 1;
         depth = 0;
         done  = 0;
         bad   = 0;
         // Walk down along the offset until a full cell is reached.
         while (!done) begin
            if (cells[c] == bbta_pkg::CELL_FULL) begin
               bad  = (offset != 0);
               done = 1;
            end else if (cells[c] != bbta_pkg::CELL_SPLIT || depth + 1 >= LEVELS) begin
               bad  = 1;
               done = 1;
            end else begin
               half = arena >> (depth + 1);
               if (offset < half) begin
                  c = c << 1;
               end else begin
                  offset -= half;
                  c = (c << 1) | 1;
               end
               depth++;
            end
         end
         if (bad) return bbta_pkg::STATUS_BAD_OFFSET;
         cells[c] = bbta_pkg::CELL_FREE;
         size     = arena >> depth;
         in_use   = (size > in_use) ? '0 : in_use - size;
         // Merge upwards while both buddies are free.
         while (c > 1 && cells[c & ~1] == bbta_pkg::CELL_FREE &&
                cells[c | 1] == bbta_pkg::CELL_FREE) begin
            c        = c >> 1;
            cells[c] = bbta_pkg::CELL_FREE;
         end
         return bbta_pkg::STATUS_OK;
      endfunction

      function void note_request(bbta_pkg::req_type item);
         bbta_pkg::rsp_type want;
         logic [31:0]       offset;
         if (item.operation == bbta_pkg::OP_ALLOC)
            want.status = allocate(item.request_size, offset);
         else
            want.status = free_block(item.free_offset);
         want.block_offset = (item.operation == bbta_pkg::OP_ALLOC &&
                              want.status == bbta_pkg::STATUS_OK) ? offset : '0;
         want.bytes_in_use = in_use;
         want.bytes_free   = (in_use > arena) ? '0 : arena - in_use;
         expected_results.push_back(want);
      endfunction

      task check_result(bbta_pkg::rsp_type got);
         bbta_pkg::rsp_type want;
         if (expected_results.size() == 0) begin
            report_mismatch("result with no item outstanding", got.block_offset, '0);
         end else begin
            want = expected_results.pop_front();
            if (got.status !== want.status)
               report_mismatch("status", 32'(got.status), 32'(want.status));
            if (got.block_offset !== want.block_offset)
               report_mismatch("block_offset", got.block_offset, want.block_offset);
            if (got.bytes_in_use !== want.bytes_in_use)
               report_mismatch("bytes_in_use", got.bytes_in_use, want.bytes_in_use);
            if (got.bytes_free !== want.bytes_free)
               report_mismatch("bytes_free", got.bytes_free, want.bytes_free);
         end
      endtask

      // Offset of a randomly chosen held block, worked out at the present arena size.
      function void pick_full_block(output bit found, output logic [31:0] offset);
         int held [$];
         int c;
         int depth;
         found  = 0;
         offset = '0;
         for (int i = 1; i < CELL_SLOTS; i++)
            if (cells[i] == bbta_pkg::CELL_FULL) held.push_back(i);
         if (held.size() == 0) return;
         c     = held[$urandom_range(0, held.size() - 1)];
         depth = 0;
         while ((c >> (depth + 1)) != 0) depth++;
         offset = path_offset(c, depth);
         found  = 1;
      endfunction
   endclass

   logic              clock          = 1'b0;
   logic              reset          = 1'b1;
   logic              req_valid      = 1'b0;
   logic              req_ready;
   bbta_pkg::req_type req_data       = '0;
   logic              rsp_valid;
   logic              rsp_ready      = 1'b0;
   bbta_pkg::rsp_type rsp_data;
   logic              csr_write_en   = 1'b0;
   logic [31:0]       csr_write_data = '0;

   alloc_result_board board;
   bit                quiet_phase = 1'b0;
   int                stall_left  = 0;
   int                cycle_count = 0;

   always #1 clock = ~clock;

   buddy_bit_tree_allocator_top #(
      .TREE_LEVELS(LEVELS)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   // Number of idle cycles before the next item on either side. In quiet phases
   // both sides run flat out.
   function int idle_cycles();
      return quiet_phase ? 0 : $urandom_range(0, 9);
   endfunction

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("** buddy_bit_tree_allocator_top: FAILED **");
         $finish;
      end
   end

   // Result side: every accepted result is checked at the edge that takes it,
   // then the receiver draws a fresh stall before it is ready again.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left = idle_cycles();
      end else begin
         if (rsp_valid && rsp_ready) begin
            board.check_result(rsp_data);
            stall_left = idle_cycles();
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Offers one item and returns at the edge that accepts it. Valid stays high
   // when the next item follows without a gap, so it is never dropped and raised
   // in the same step.
   task send_item(bbta_pkg::req_type item);
      int gap;
      gap = idle_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      board.note_request(item);
   endtask

   task send_alloc(logic [31:0] size);
      bbta_pkg::req_type item;
      item.operation    = bbta_pkg::OP_ALLOC;
      item.request_size = size;
      item.free_offset  = $urandom;
      send_item(item);
   endtask

   task send_free(logic [31:0] offset);
      bbta_pkg::req_type item;
      item.operation    = bbta_pkg::OP_FREE;
      item.request_size = $urandom;
      item.free_offset  = offset;
      send_item(item);
   endtask

   // Drops valid and waits until every outstanding result has come back, so the
   // block is idle afterwards.
   task settle();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   task write_arena(logic [31:0] value);
      settle();
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      board.set_arena(value);
   endtask

   // Random item: mostly allocations sized for a chosen level and frees of blocks
   // that are really held, the rest zero sizes, oversized requests and bad offsets.
   function bbta_pkg::req_type random_request();
      bbta_pkg::req_type item;
      int                pick;
      int                depth;
      logic [31:0]       hi_size;
      logic [31:0]       lo_size;
      logic [31:0]       offset;
      bit                found;
      item.operation    = bbta_pkg::OP_ALLOC;
      item.request_size = $urandom;
      item.free_offset  = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         depth   = $urandom_range(0, LEVELS - 1);
         hi_size = board.arena >> depth;
         lo_size = (depth == LEVELS - 1) ? 32'd1 : (board.arena >> (depth + 1)) + 1;
         if (hi_size == 0) hi_size = 1;
         if (lo_size > hi_size) lo_size = hi_size;
         item.request_size = $urandom_range(hi_size, lo_size);
      end else if (pick < 88) begin
         item.operation = bbta_pkg::OP_FREE;
         board.pick_full_block(found, offset);
         item.free_offset = found ? offset : $urandom_range(board.arena - 1, 0);
      end else begin
         case ($urandom_range(0, 4))
            0: item.request_size = '0;
            1: item.request_size = (board.arena == '1) ? '1 :
                                   $urandom_range(32'hFFFF_FFFF, board.arena + 1);
            2: item.operation = bbta_pkg::OP_FREE;
            3: begin
               item.operation = bbta_pkg::OP_FREE;
               board.pick_full_block(found, offset);
               item.free_offset = offset + $urandom_range(1, 3);
            end
            default: begin
               item.operation   = bbta_pkg::OP_FREE;
               item.free_offset = $urandom_range(board.arena - 1, 0);
            end
         endcase
      end
      return item;
   endfunction

   logic [31:0] arena_choices [RANDOM_PHASES];

   initial begin
      board = new();
      arena_choices = '{32'd4096, 32'd100, 32'hFFFF_FFFF, 32'd7,
                        32'd1, 32'h8000_0000, 32'd0, 32'd4096};
      // One phase gets a random, non-zero arena size.
      arena_choices[6] = $urandom | 32'd1;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed items at the reset arena of 4096 bytes. Rejections first: a zero
      // size, a request bigger than the arena and frees with nothing held.
      send_alloc(32'd0);
      send_alloc(32'd4097);
      send_free(32'd0);
      send_free(32'hFFFF_FFFF);
      // The whole arena as one block; nothing fits under it and an offset inside
      // it is not a block start.
      send_alloc(32'd4096);
      send_alloc(32'd1);
      send_free(32'd1);
      send_free(32'd0);
      // Fill the tree with blocks of every size under the arena, then free them so
      // buddies merge back up to the root, with a free that lands mid-block on the way.
      send_alloc(32'd1);
      send_alloc(32'd512);
      send_alloc(32'd513);
      send_alloc(32'd2048);
      send_free(32'd512);
      send_free(32'd256);
      send_free(32'd0);
      send_free(32'd1024);
      send_free(32'd2048);
      send_free(32'd0);

      // Rewriting the arena while blocks are held drives the byte total into
      // saturation at both ends and makes bytes_free clamp to zero.
      write_arena(32'hFFFF_FFFF);
      send_alloc(32'h8000_0000);
      write_arena(32'd16);
      send_free(32'd0);
      write_arena(32'hFFFF_FFFF);
      send_alloc(32'hFFFF_FFFF);
      send_free(32'd0);
      write_arena(32'd16);
      send_alloc(32'd16);
      write_arena(32'hFFFF_FFFF);
      send_free(32'd0);
      // Smallest arena: a request that fits lands on the root, a larger one is refused.
      write_arena(32'd1);
      send_alloc(32'd1);
      send_alloc(32'd2);
      send_free(32'd0);

      // Random phases. The tree is carried over from one arena size to the next,
      // so stale blocks get freed under a different geometry too.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_arena(arena_choices[phase]);
         quiet_phase = (phase == 1) || ($urandom_range(0, 4) == 0);
         repeat (RANDOM_ITEMS / RANDOM_PHASES) send_item(random_request());
      end

      settle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.error_count == 0) begin
         $display("** buddy_bit_tree_allocator_top: PASSED **");
      end else begin
         $display("** buddy_bit_tree_allocator_top: FAILED **");
      end
      $finish;
   end

endmodule
